// ===== hdl/mtf_pkg.sv =====
package mtf_pkg;

  localparam int SYM_W = 9;
  localparam int POS_W = 9;

endpackage

// ===== hdl/move_to_front_encoder.sv =====
// move-to-front encoder built as a row of symbol cells, front cell first
// an accepted symbol and its cell matches are captured, then the position is registered on the output
// once the output is free; in-range symbols go through capture, encode and a shift of the cell row,
// out-of-range symbols only through capture and encode; encode holds while the output is not taken
// a new symbol is taken once these steps end, while the previous position still waits on the output
// reset: synchronous, cells return to natural order 1..SYMBOLS at once, no sweep
module move_to_front_encoder #(
  parameter int SYMBOLS = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mtf_pkg::SYM_W-1:0] symbol,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mtf_pkg::POS_W-1:0] position
);

  localparam int VAL_W = $clog2(SYMBOLS + 1);
  localparam int IW    = $clog2(SYMBOLS);
  localparam int PW    = (IW + 1 > mtf_pkg::POS_W) ? IW + 1 : mtf_pkg::POS_W;

  typedef enum logic [1:0] {S_IDLE, S_ENC, S_SHIFT} state_t;

  state_t                    state;
  logic [mtf_pkg::SYM_W-1:0] sym_q;
  logic                      in_range_q;
  logic [SYMBOLS-1:0]        match_q;
  logic [IW-1:0]             idx_q;
  logic [SYMBOLS-1:0]        match;
  logic [SYMBOLS-1:0]        shift_en;
  logic [VAL_W-1:0]          cell_val [SYMBOLS];
  logic [IW-1:0]             enc_idx;
  logic                      in_range;
  logic                      out_free;
  logic [PW-1:0]             pos_full;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign in_range = (symbol != '0) && (32'(symbol) <= 32'(SYMBOLS));
  assign pos_full = PW'(enc_idx) + PW'(1);

  for (genvar j = 0; j < SYMBOLS; j++) begin : g_cell
    logic [VAL_W-1:0] din;
    if (j == 0) begin : g_front
      assign din = VAL_W'(sym_q);
    end else begin : g_rest
      assign din = cell_val[j-1];
    end
    assign shift_en[j] = (state == S_SHIFT) && (IW'(j) <= idx_q);
    mtf_cell #(
      .VAL_W (VAL_W),
      .INIT  (j + 1)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .key   (symbol),
      .shift (shift_en[j]),
      .din   (din),
      .value (cell_val[j]),
      .match (match[j])
    );
  end

  mtf_enc #(
    .N  (SYMBOLS),
    .IW (IW)
  ) u_enc (
    .onehot (match_q),
    .idx    (enc_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      in_range_q <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_ENC)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            sym_q      <= symbol;
            in_range_q <= in_range;
            match_q    <= match;
            state      <= S_ENC;
          end
        end
        S_ENC: begin
          if (out_free) begin
            idx_q     <= enc_idx;
            out_valid <= 1'b1;
            position  <= in_range_q ? pos_full[mtf_pkg::POS_W-1:0] : '0;
            state     <= in_range_q ? S_SHIFT : S_IDLE;
          end
        end
        S_SHIFT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // exactly one cell holds an in-range symbol
  a_onehot_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC && in_range_q) |-> $onehot(match_q))
    else $error("in-range symbol did not hit exactly one cell");

  a_no_hit_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_ENC && !in_range_q) |-> (match_q == '0))
    else $error("out-of-range symbol hit a cell");

  a_front_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |=> (cell_val[0] == VAL_W'($past(sym_q))))
    else $error("front cell not loaded with encoded symbol");

  a_out_from_enc: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ENC))
    else $error("result raised outside encode step");

endmodule

// ===== hdl/mtf_cell.sv =====
module mtf_cell #(
  parameter int VAL_W = 9,
  parameter int INIT  = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [mtf_pkg::SYM_W-1:0] key,
  input  logic                    shift,
  input  logic [VAL_W-1:0]        din,
  output logic [VAL_W-1:0]        value,
  output logic                    match
);

  localparam int CMP_W = (VAL_W > mtf_pkg::SYM_W) ? VAL_W : mtf_pkg::SYM_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= VAL_W'(INIT);
    end else if (shift) begin
      value <= din;
    end
  end

  assign match = (CMP_W'(value) == CMP_W'(key));

endmodule

// ===== hdl/mtf_enc.sv =====
module mtf_enc #(
  parameter int N  = 256,
  parameter int IW = 8
) (
  input  logic [N-1:0]  onehot,
  output logic [IW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int k = 0; k < N; k++) begin
      if (onehot[k]) begin
        idx = idx | IW'(k);
      end
    end
  end

endmodule
